### sv/lrtf_pkg.sv
// shared constants and types for the longest-remaining-time-first scheduler
`default_nettype none
package lrtf_pkg;
  localparam int MAX_PROCS = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ID_W      = 5;
  localparam int T_W       = 21;
  localparam int SUM_W     = 25;

  typedef struct packed {
    logic [TIME_BITS-1:0] arr;
    logic [TIME_BITS-1:0] bur;
    logic [TIME_BITS-1:0] rem;
    logic [T_W-1:0]       start;
    logic [T_W-1:0]       fin;
  } proc_ent_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    proc_ent_t        data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_CHECK, ST_SCAN, ST_DECIDE, ST_ORD, ST_OCALC, ST_OWAIT
  } state_e;
endpackage
`default_nettype wire

### sv/lrtf_proc_mem.sv
// process record memory, one write and one registered read port
`default_nettype none
module lrtf_proc_mem import lrtf_pkg::*; (
  input  wire logic             clk_i,
  input  wire mem_wr_t          wr_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output proc_ent_t             rdata_o
);
  proc_ent_t mem [MAX_PROCS];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### sv/lrtf_schedule_simulator.sv
// top level: load, tick-by-tick scheduling over the record memory, result output
// load: one cycle per item; the final item (s_tlast, or the MAX_PROCS-th record) starts the simulation
// each tick scans all loaded records through the memory read port;
//   the number of ticks is the sum of bursts plus idle jumps
// results: one per pass through ST_ORD, ST_OCALC and ST_OWAIT, held while the output stalls, in index order
// reset (async, active low) empties the set; the block returns there after the last result
`default_nettype none
module lrtf_schedule_simulator import lrtf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // arrival, burst
  input  wire logic         s_tlast,   // last_process
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [167:0]      m_tdata,   // proc_id, completion, turnaround, waiting, response,
                                       // sum_turnaround, sum_waiting, sum_response, zero pad
  output logic              m_tlast    // last_result
);
  state_e state_q, state_d;
  logic [CNT_W-1:0] loaded_q, loaded_d, finished_q, finished_d;
  logic [T_W-1:0]   sim_q, sim_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rv_q, rv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             hpick_q, hpick_d, hmin_q, hmin_d;
  logic [IDX_W-1:0] pidx_q, pidx_d;
  proc_ent_t        pent_q, pent_d;
  logic [TIME_BITS-1:0] minarr_q, minarr_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [SUM_W-1:0] st_q, st_d, sw_q, sw_d, sr_q, sr_d;
  logic [167:0]     od_q, od_d;
  logic             ol_q, ol_d;

  mem_wr_t          wr;
  logic [IDX_W-1:0] raddr;
  proc_ent_t        rd;

  lrtf_proc_mem u_mem (.clk_i(clk_i), .wr_i(wr), .raddr_i(raddr), .rdata_o(rd));

  logic [TIME_BITS-1:0] in_arr, in_bur;
  logic [IDX_W-1:0]     load_idx;
  logic                 elig, better;
  logic [TIME_BITS-1:0] rem_dec;
  logic [T_W-1:0]       tat, wt, rt;
  logic                 fin_out;

  assign in_arr   = s_tdata[TIME_BITS-1:0];
  assign in_bur   = s_tdata[2*TIME_BITS-1:TIME_BITS];
  assign load_idx = loaded_q[IDX_W-1:0];
  assign elig     = !done_q[ridx_q] && ({{(T_W-TIME_BITS){1'b0}}, rd.arr} <= sim_q);
  assign better   = !hpick_q || (rd.rem > pent_q.rem) ||
                    ((rd.rem == pent_q.rem) && (rd.arr < pent_q.arr));
  assign rem_dec  = pent_q.rem - 1'b1;
  assign tat      = rd.fin - {{(T_W-TIME_BITS){1'b0}}, rd.arr};
  assign wt       = tat - {{(T_W-TIME_BITS){1'b0}}, rd.bur};
  assign rt       = rd.start - {{(T_W-TIME_BITS){1'b0}}, rd.arr};
  assign fin_out  = ({{(CNT_W-IDX_W){1'b0}}, oidx_q} + 1'b1) == loaded_q;

  assign s_tready = (state_q == ST_LOAD);
  assign m_tvalid = (state_q == ST_OWAIT);
  assign m_tdata  = od_q;
  assign m_tlast  = ol_q;

  always_comb begin
    state_d = state_q; loaded_d = loaded_q; finished_d = finished_q; sim_d = sim_q;
    done_d = done_q; issue_d = issue_q; rv_d = 1'b0; ridx_d = ridx_q;
    hpick_d = hpick_q; hmin_d = hmin_q; pidx_d = pidx_q; pent_d = pent_q;
    minarr_d = minarr_q; oidx_d = oidx_q; st_d = st_q; sw_d = sw_q; sr_d = sr_q;
    od_d = od_q; ol_d = ol_q;
    wr = '0; raddr = oidx_q;
    unique case (state_q)
      ST_LOAD: begin
        if (s_tvalid) begin
          wr.en = 1'b1; wr.addr = load_idx;
          wr.data.arr = in_arr; wr.data.bur = in_bur; wr.data.rem = in_bur;
          wr.data.start = (in_bur == '0) ? {{(T_W-TIME_BITS){1'b0}}, in_arr} : '0;
          wr.data.fin   = (in_bur == '0) ? {{(T_W-TIME_BITS){1'b0}}, in_arr} : '0;
          done_d[load_idx] = (in_bur == '0);
          if (in_bur == '0) finished_d = finished_q + 1'b1;
          loaded_d = loaded_q + 1'b1;
          if (s_tlast || (loaded_d == CNT_W'(MAX_PROCS))) state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        issue_d = '0; hpick_d = 1'b0; hmin_d = 1'b0;
        if (finished_q == loaded_q) begin
          oidx_d = '0; state_d = ST_ORD;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q < loaded_q) begin
          raddr = issue_q[IDX_W-1:0];
          rv_d = 1'b1; ridx_d = issue_q[IDX_W-1:0];
          issue_d = issue_q + 1'b1;
        end
        if (rv_q) begin
          if (elig && better) begin
            hpick_d = 1'b1; pidx_d = ridx_q; pent_d = rd;
          end
          if (!done_q[ridx_q] && (!hmin_q || rd.arr < minarr_q)) begin
            hmin_d = 1'b1; minarr_d = rd.arr;
          end
          if (({{(CNT_W-IDX_W){1'b0}}, ridx_q} + 1'b1) == loaded_q) state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hpick_q) begin
          wr.en = 1'b1; wr.addr = pidx_q; wr.data = pent_q;
          wr.data.rem = rem_dec;
          if (pent_q.rem == pent_q.bur) wr.data.start = sim_q;
          sim_d = sim_q + 1'b1;
          if (rem_dec == '0) begin
            wr.data.fin = sim_d;
            done_d[pidx_q] = 1'b1;
            finished_d = finished_q + 1'b1;
          end
        end else if (hmin_q && ({{(T_W-TIME_BITS){1'b0}}, minarr_q} > sim_q)) begin
          sim_d = {{(T_W-TIME_BITS){1'b0}}, minarr_q};
        end else begin
          sim_d = sim_q + 1'b1;
        end
        state_d = ST_CHECK;
      end
      ST_ORD: begin
        raddr = oidx_q;
        state_d = ST_OCALC;
      end
      ST_OCALC: begin
        st_d = st_q + SUM_W'(tat);
        sw_d = sw_q + SUM_W'(wt);
        sr_d = sr_q + SUM_W'(rt);
        od_d = {4'b0000,
                fin_out ? sr_d : {SUM_W{1'b0}},
                fin_out ? sw_d : {SUM_W{1'b0}},
                fin_out ? st_d : {SUM_W{1'b0}},
                rt, wt, tat, rd.fin,
                ID_W'({{(CNT_W-IDX_W){1'b0}}, oidx_q} + 1'b1)};
        ol_d = fin_out;
        state_d = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (m_tready) begin
          if (ol_q) begin
            loaded_d = '0; finished_d = '0; sim_d = '0; done_d = '0;
            st_d = '0; sw_d = '0; sr_d = '0;
            state_d = ST_LOAD;
          end else begin
            oidx_d = oidx_q + 1'b1;
            state_d = ST_ORD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; loaded_q <= '0; finished_q <= '0; sim_q <= '0;
      done_q <= '0; issue_q <= '0; rv_q <= 1'b0; hpick_q <= 1'b0; hmin_q <= 1'b0;
      oidx_q <= '0; st_q <= '0; sw_q <= '0; sr_q <= '0; ol_q <= 1'b0;
    end else begin
      state_q <= state_d; loaded_q <= loaded_d; finished_q <= finished_d; sim_q <= sim_d;
      done_q <= done_d; issue_q <= issue_d; rv_q <= rv_d; hpick_q <= hpick_d;
      hmin_q <= hmin_d; oidx_q <= oidx_d; st_q <= st_d; sw_q <= sw_d; sr_q <= sr_d;
      ol_q <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d; pidx_q <= pidx_d; pent_q <= pent_d; minarr_q <= minarr_d;
    od_q <= od_d;
  end
endmodule
`default_nettype wire

### sv/lrtf_checker.sv
// port-level checks for the scheduler top level
`default_nettype none
module lrtf_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [167:0] m_tdata,
  input wire logic         m_tlast
);
  // loading and result output never overlap
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready && m_tvalid)) else $error("input ready while results pending");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // sums only on the final result
  a_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tlast |-> m_tdata[163:89] == '0) else $error("sums on non-final item");

  a_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[4:0] != 5'd0) else $error("zero process id");

  // after the final result the block goes back to loading
  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tready && m_tlast |=> s_tready) else $error("no reload after set");
endmodule

bind lrtf_schedule_simulator lrtf_checker u_lrtf_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
